// File: sv/free_list_node_pool_stack_core_defines.svh
// Assertion macros for the free list node pool stack core.
// Included by the top level; relies on aclk and aresetn being in scope.
`ifndef FREE_LIST_NODE_POOL_STACK_CORE_DEFINES_SVH
`define FREE_LIST_NODE_POOL_STACK_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FLNPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FLNPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/flnps_pkg.sv
// Shared types, sizes and helpers for the free list node pool stack core.
// No dependencies; imported by the top level.
`default_nettype none

package flnps_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
    localparam int LINK_W     = 7;
    localparam int DATA_W     = 32;

    localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_POP    = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_RESP,
        ST_POP_RD,
        ST_POP_OUT,
        ST_LIST_RD,
        ST_LIST_OUT
    } state_t;

    // Link held by a slot that has not been written since reset.
    function automatic logic [LINK_W-1:0] link_reset(input logic [SLOT_W-1:0] slot);
        logic [LINK_W-1:0] result;
        if (LINK_W'(slot) == LINK_W'(POOL_SLOTS - 1)) begin
            result = LINK_NONE;
        end else begin
            result = LINK_W'(slot) + LINK_W'(1);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// File: sv/flnps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module flnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/free_list_node_pool_stack_core.sv
// Top level of the free list node pool stack core: control sequencer and three memories.
// Depends on flnps_pkg, flnps_ram and free_list_node_pool_stack_core_defines.svh.
`default_nettype none

`include "free_list_node_pool_stack_core_defines.svh"

// The core keeps a stack of 32-bit signed values in a pool of POOL_SLOTS node slots
// handed out from a free list. Each input transaction carries a command in s_tuser
// (append, pop or list) and, for append, the value in s_tdata. Append and pop answer
// with one result transaction; list answers with one transaction per stored value,
// oldest first, with m_tlast on the final one, or a single "empty" status if nothing
// is stored. Overflow, underflow and empty are reported in m_tuser with zero data and
// m_tlast high; an unknown command is dropped without a result. One command is handled
// at a time. Since every memory read is registered, an append or a rejected command
// waits in the append or response state, a pop in read and output states, and a list
// in read and output states per value: an order-table read, then a value read.
// A result that is not taken stalls the sequencer only when the next result is due;
// the output register lets a new command be accepted while a result waits. The value
// store and the order table need no initialisation; the reset state of the free-list
// links is supplied by one valid flag per slot, so no clearing pass follows reset.
module free_list_node_pool_stack_core
    import flnps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input channel
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [31:0] value
    input  wire logic [1:0]        s_tuser,   // [1:0] command
    // Result channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [31:0]       m_tdata,   // [31:0] data
    output logic      [1:0]        m_tuser,   // [1:0] status
    output logic                   m_tlast
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [LINK_W-1:0]     fh_reg, fh_next;            // head of the free list
    logic [CNT_W-1:0]      count_reg, count_next;      // stored elements
    logic [SLOT_W-1:0]     idx_reg, idx_next;          // list position
    status_t               status_reg, status_next;    // pending error status
    logic [SLOT_W-1:0]     fh_rd_reg, fh_rd_next;      // slot whose link is read
    logic                  link_hit_reg, link_hit_next;
    logic [POOL_SLOTS-1:0] link_valid_reg, link_valid_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]     m_data_reg, m_data_next;
    status_t               m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic              val_wr_en, val_rd_en;
    logic [SLOT_W-1:0] val_wr_addr, val_rd_addr;
    logic [DATA_W-1:0] val_wr_data, val_rd_data;

    logic              link_wr_en, link_rd_en;
    logic [SLOT_W-1:0] link_wr_addr, link_rd_addr;
    logic [LINK_W-1:0] link_wr_data, link_rd_data;

    logic              ord_wr_en, ord_rd_en;
    logic [SLOT_W-1:0] ord_wr_addr, ord_rd_addr;
    logic [SLOT_W-1:0] ord_wr_data, ord_rd_data;

    // Slot values, indexed by slot.
    flnps_ram #(.WIDTH(DATA_W), .DEPTH(POOL_SLOTS)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_en   (val_rd_en),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    // Free-list links, indexed by slot. Only free-list links are kept: the links
    // between stored elements are never read before being overwritten on pop.
    flnps_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    // Order table: slot of the i-th stored element, oldest first.
    flnps_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_order_ram (
        .aclk    (aclk),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data),
        .rd_en   (ord_rd_en),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    cmd_t              in_cmd;
    logic              in_fire;
    logic              out_free;
    logic              pool_full;
    logic              list_empty;
    logic              list_last;
    logic [CNT_W-1:0]  count_m1;

    assign in_cmd     = cmd_t'(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    // The output register can take a new result when it is empty or being emptied.
    assign out_free   = !m_tvalid_reg || m_tready;
    // The free-head check cannot fire after reset but still guards the pool.
    assign pool_full  = (count_reg >= CNT_W'(POOL_SLOTS)) || (fh_reg >= LINK_W'(POOL_SLOTS));
    assign list_empty = (count_reg == '0);
    assign count_m1   = count_reg - CNT_W'(1);
    assign list_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_cmd)
                        CMD_APPEND: state_next = pool_full ? ST_RESP : ST_APPEND;
                        CMD_POP:    state_next = list_empty ? ST_RESP : ST_POP_RD;
                        CMD_LIST:   state_next = list_empty ? ST_RESP : ST_LIST_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_APPEND:  state_next = out_free ? ST_IDLE : ST_APPEND;
            ST_RESP:    state_next = out_free ? ST_IDLE : ST_RESP;
            ST_POP_RD:  state_next = ST_POP_OUT;
            ST_POP_OUT: state_next = out_free ? ST_IDLE : ST_POP_OUT;
            ST_LIST_RD: state_next = ST_LIST_OUT;
            ST_LIST_OUT: begin
                if (out_free) begin
                    state_next = list_last ? ST_IDLE : ST_LIST_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Memory control, datapath updates and result loading
    // ------------------------------------------------------------------
    always_comb begin
        val_wr_en     = 1'b0;
        val_wr_addr   = fh_reg[SLOT_W-1:0];
        val_wr_data   = s_tdata;
        val_rd_en     = 1'b0;
        val_rd_addr   = ord_rd_data;
        link_wr_en    = 1'b0;
        link_wr_addr  = ord_rd_data;
        link_wr_data  = fh_reg;
        link_rd_en    = 1'b0;
        link_rd_addr  = fh_reg[SLOT_W-1:0];
        ord_wr_en     = 1'b0;
        ord_wr_addr   = count_reg[SLOT_W-1:0];
        ord_wr_data   = fh_reg[SLOT_W-1:0];
        ord_rd_en     = 1'b0;
        ord_rd_addr   = count_m1[SLOT_W-1:0];

        fh_next       = fh_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        fh_rd_next    = fh_rd_reg;
        link_hit_next = link_hit_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_cmd)
                        CMD_APPEND: begin
                            if (pool_full) begin
                                status_next = STAT_OVERFLOW;
                            end else begin
                                // Store the value, record the slot as the new tail
                                // and fetch the next free slot.
                                val_wr_en     = 1'b1;
                                ord_wr_en     = 1'b1;
                                link_rd_en    = 1'b1;
                                fh_rd_next    = fh_reg[SLOT_W-1:0];
                                link_hit_next = link_valid_reg[fh_reg[SLOT_W-1:0]];
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (list_empty) begin
                                status_next = STAT_UNDERFLOW;
                            end else begin
                                ord_rd_en = 1'b1;
                            end
                        end
                        CMD_LIST: begin
                            if (list_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                ord_rd_en   = 1'b1;
                                ord_rd_addr = '0;
                                idx_next    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                if (out_free) begin
                    // A slot never written since reset still carries its reset link.
                    fh_next       = link_hit_reg ? link_rd_data : link_reset(fh_rd_reg);
                    m_tvalid_next = 1'b1;
                    m_data_next   = '0;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = '0;
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                end
            end
            ST_POP_RD: begin
                // The tail slot is known: read its value and push it on the free list.
                val_rd_en  = 1'b1;
                link_wr_en = 1'b1;
                fh_next    = LINK_W'(ord_rd_data);
                count_next = count_m1;
            end
            ST_POP_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = val_rd_data;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                end
            end
            ST_LIST_RD: begin
                val_rd_en = 1'b1;
            end
            ST_LIST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = val_rd_data;
                    m_status_next = STAT_OK;
                    m_last_next   = list_last;
                    if (!list_last) begin
                        idx_next    = idx_reg + SLOT_W'(1);
                        ord_rd_en   = 1'b1;
                        ord_rd_addr = idx_reg + SLOT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        link_valid_next = link_valid_reg;
        if (link_wr_en) begin
            link_valid_next[link_wr_addr] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fh_reg         <= '0;
            count_reg      <= '0;
            link_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fh_reg         <= fh_next;
            count_reg      <= count_next;
            link_valid_reg <= link_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        fh_rd_reg    <= fh_rd_next;
        link_hit_reg <= link_hit_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FLNPS_ASSERT_ALWAYS(a_free_head_in_pool,
        (count_reg >= CNT_W'(POOL_SLOTS)) || (fh_reg < LINK_W'(POOL_SLOTS)),
        "free list head is outside the pool while slots remain")
    `FLNPS_ASSERT_NEXT(a_append_counts,
        in_fire && (in_cmd == CMD_APPEND) && !pool_full,
        count_reg == $past(count_reg) + CNT_W'(1),
        "accepted append did not add one element")
    `FLNPS_ASSERT_NEXT(a_pop_counts,
        state_reg == ST_POP_RD,
        count_reg == $past(count_reg) - CNT_W'(1),
        "accepted pop did not remove one element")

endmodule

`default_nettype wire
